[design/lswc_pkg.sv]
// Shared types and constants for the line segment window clipper.
// No dependencies.
package lswc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int RATIO_W    = QUO_BITS + 2;
	localparam int PROD_W     = QUO_BITS + 1 + DIFF_W;
	localparam int N_EDGES    = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		REG_XL = 2'd0,
		REG_XH = 2'd1,
		REG_YL = 2'd2,
		REG_YH = 2'd3
	} reg_idx_t;

	// per-edge classification
	typedef struct packed {
		logic pz;    // p == 0
		logic pneg;  // p < 0, entry edge
		logic rneg;  // ratio sign (q sign when p == 0)
		logic sat;   // |q| >= 2|p|, ratio beyond range
	} edge_flags_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		edge_flags_t [N_EDGES-1:0] fl;
	} side_t;

	typedef struct packed {
		side_t                          side;
		logic [N_EDGES-1:0][DIFF_W-1:0] qmag;
		logic [N_EDGES-1:0][DIFF_W-1:0] pmag;
	} item_t;

endpackage

[design/line_segment_window_clipper.sv]
// Line segment window clipper, top level: APB window registers, front, queue, back.
// Depends on lswc_pkg, lswc_front, lswc_fifo, lswc_back.
//
// Liang-Barsky clipping of one segment per transfer against the window held in
// four APB registers (x low, x high, y low, y high at 0x0, 0x4, 0x8, 0xC, signed
// Q15.16). A segment goes in with push while full is low. Its result (visible
// and the clipped endpoints, all zero when rejected) appears when empty goes low
// and leaves with pop. One segment is accepted every cycle while full is low. The
// result passes from the front register through the queue, then 17 divider
// stages (one quotient bit each, four dividers side by side), the range combine,
// the multiply and the output register. A stalled result stops the back pipeline
// while the front keeps taking segments until the queue fills.
module line_segment_window_clipper import lswc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic                      empty,
	input  logic                      pop,
	output logic                      visible,
	output logic signed [COORD_W-1:0] clipped_start_x,
	output logic signed [COORD_W-1:0] clipped_start_y,
	output logic signed [COORD_W-1:0] clipped_end_x,
	output logic signed [COORD_W-1:0] clipped_end_y
);
	logic signed [COORD_W-1:0] wxl_q, wxh_q, wyl_q, wyh_q;
	reg_idx_t                  ridx;
	logic                      wr_en;
	logic                      q_wr, q_full, q_rd, q_empty;
	item_t                     q_wdata, q_rdata;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wxl_q <= '0;
			wxh_q <= COORD_W'(1 << FRAC_BITS);
			wyl_q <= '0;
			wyh_q <= COORD_W'(1 << FRAC_BITS);
		end else if (wr_en) begin
			case (ridx)
				REG_XL:  wxl_q <= pwdata;
				REG_XH:  wxh_q <= pwdata;
				REG_YL:  wyl_q <= pwdata;
				REG_YH:  wyh_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_XL:  prdata = wxl_q;
			REG_XH:  prdata = wxh_q;
			REG_YL:  prdata = wyl_q;
			REG_YH:  prdata = wyh_q;
			default: prdata = '0;
		endcase
	end

	// front: edge distances and classification
	lswc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.wxl     (wxl_q),
		.wxh     (wxh_q),
		.wyl     (wyl_q),
		.wyh     (wyh_q),
		.q_wr    (q_wr),
		.q_wdata (q_wdata),
		.q_full  (q_full)
	);

	// decoupling queue
	lswc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back: ratios, range, endpoints
	lswc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_rdata         (q_rdata),
		.q_empty         (q_empty),
		.q_rd            (q_rd),
		.empty           (empty),
		.pop             (pop),
		.visible         (visible),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y)
	);

	// rejected segments carry zero endpoints
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !visible) |-> (clipped_start_x == '0 && clipped_start_y == '0 &&
		                          clipped_end_x == '0 && clipped_end_y == '0))
		else $error("rejected segment with nonzero endpoints");

	// a write to the x high register lands in that register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && ridx == REG_XH) |=> (wxh_q == $past(pwdata)))
		else $error("window register write lost");

	// queue never overflows: no write while full
	a_queue_wr: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr)
		else $error("queue written while full");
endmodule

[design/lswc_fifo.sv]
// Short queue between front and back of the clipper.
// Depends on lswc_pkg.
module lswc_fifo import lswc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	output logic  full,
	input  logic  rd,
	output item_t rdata,
	output logic  empty
);
	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd)      cnt_q <= cnt_q + 1'b1;
			else if (!wr && rd) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

[design/lswc_front.sv]
// Front end: takes segments, forms edge distances and classifies each edge.
// Depends on lswc_pkg.
module lswc_front import lswc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic signed [COORD_W-1:0] wxl,
	input  logic signed [COORD_W-1:0] wxh,
	input  logic signed [COORD_W-1:0] wyl,
	input  logic signed [COORD_W-1:0] wyh,
	output logic                      q_wr,
	output item_t                     q_wdata,
	input  logic                      q_full
);
	logic                              vld_s1;
	item_t                             item_s1;
	item_t                             item_d;
	logic signed [N_EDGES-1:0][DIFF_W-1:0] p, q;
	logic                              adv;

	assign adv     = !vld_s1 || !q_full;
	assign full    = !adv;
	assign q_wr    = vld_s1 && !q_full;
	assign q_wdata = item_s1;

	always_comb begin
		item_d.side.x0 = start_x;
		item_d.side.y0 = start_y;
		item_d.side.dx = DIFF_W'(end_x) - DIFF_W'(start_x);
		item_d.side.dy = DIFF_W'(end_y) - DIFF_W'(start_y);
		p[0] = -item_d.side.dx;
		q[0] = DIFF_W'(start_x) - DIFF_W'(wxl);
		p[1] = item_d.side.dx;
		q[1] = DIFF_W'(wxh) - DIFF_W'(start_x);
		p[2] = -item_d.side.dy;
		q[2] = DIFF_W'(start_y) - DIFF_W'(wyl);
		p[3] = item_d.side.dy;
		q[3] = DIFF_W'(wyh) - DIFF_W'(start_y);
		for (int e = 0; e < N_EDGES; e++) begin
			item_d.pmag[e] = p[e][DIFF_W-1] ? -p[e] : p[e];
			item_d.qmag[e] = q[e][DIFF_W-1] ? -q[e] : q[e];
			item_d.side.fl[e].pz   = (p[e] == '0);
			item_d.side.fl[e].pneg = p[e][DIFF_W-1];
			item_d.side.fl[e].rneg = q[e][DIFF_W-1] ^ p[e][DIFF_W-1];
			item_d.side.fl[e].sat  = ({1'b0, item_d.qmag[e]} >= {item_d.pmag[e], 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (push && adv) item_s1 <= item_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
		end
	end
endmodule

[design/lswc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lswc_pkg.
module lswc_div import lswc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIFF_W-1:0] num,
	input  logic [DIFF_W-1:0] den,
	output logic [QUO_BITS-1:0] quo
);
	logic [DIFF_W-1:0]   rem_s [QUO_BITS];
	logic [DIFF_W-1:0]   den_s [QUO_BITS];
	logic [QUO_BITS-1:0] quo_s [QUO_BITS];

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		logic [DIFF_W:0]   cand, diff;
		logic [DIFF_W-1:0] dv;
		logic [QUO_BITS-1:0] qprev;
		logic              qbit;
		if (k == 0) begin : g_first
			assign cand  = {1'b0, num};
			assign dv    = den;
			assign qprev = '0;
		end else begin : g_next
			assign cand  = {rem_s[k-1], 1'b0};
			assign dv    = den_s[k-1];
			assign qprev = quo_s[k-1];
		end
		assign diff = cand - {1'b0, dv};
		assign qbit = (cand >= {1'b0, dv});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= qbit ? diff[DIFF_W-1:0] : cand[DIFF_W-1:0];
				den_s[k] <= dv;
				quo_s[k] <= {qprev[QUO_BITS-2:0], qbit};
			end
		end
	end

	assign quo = quo_s[QUO_BITS-1];
endmodule

[design/lswc_back.sv]
// Back end: edge ratios by divider pipelines, parameter range, endpoint math.
// Depends on lswc_pkg and lswc_div.
module lswc_back import lswc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  item_t                     q_rdata,
	input  logic                      q_empty,
	output logic                      q_rd,
	output logic                      empty,
	input  logic                      pop,
	output logic                      visible,
	output logic signed [COORD_W-1:0] clipped_start_x,
	output logic signed [COORD_W-1:0] clipped_start_y,
	output logic signed [COORD_W-1:0] clipped_end_x,
	output logic signed [COORD_W-1:0] clipped_end_y
);
	logic                              adv;
	logic [QUO_BITS-1:0]               vld_q;
	side_t                             side_s [QUO_BITS];
	logic [N_EDGES-1:0][QUO_BITS-1:0]  quo;

	logic                              vld_s2, ok_s2;
	logic [QUO_BITS-1:0]               tin_s2, tout_s2;
	side_t                             side_s2;
	logic                              vld_s3, ok_s3;
	logic signed [COORD_W-1:0]         x0_s3, y0_s3;
	logic signed [PROD_W-1:0]          pix_s3, piy_s3, pox_s3, poy_s3;
	logic                              out_vld_q, vis_q;
	logic signed [COORD_W-1:0]         sx_q, sy_q, ex_q, ey_q;

	logic signed [RATIO_W-1:0]         tin, tout, ratio;
	logic [RATIO_W-2:0]                mag;
	logic                              rej;

	assign adv   = !out_vld_q || pop;
	assign q_rd  = adv && !q_empty;
	assign empty = !out_vld_q;

	for (genvar e = 0; e < N_EDGES; e++) begin : g_div
		lswc_div u_div (
			.clk (clk),
			.en  (adv),
			.num (q_rdata.qmag[e]),
			.den (q_rdata.pmag[e]),
			.quo (quo[e])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= q_rdata.side;
			for (int k = 1; k < QUO_BITS; k++) side_s[k] <= side_s[k-1];
		end
	end

	// entry = max of entering ratios, exit = min of leaving ratios
	always_comb begin
		tin  = '0;
		tout = RATIO_W'(1 << FRAC_BITS);
		rej  = 1'b0;
		for (int e = 0; e < N_EDGES; e++) begin
			mag   = side_s[QUO_BITS-1].fl[e].sat ? (RATIO_W-1)'(1 << QUO_BITS)
			                                   : (RATIO_W-1)'(quo[e]);
			ratio = side_s[QUO_BITS-1].fl[e].rneg ? -$signed({1'b0, mag})
			                                      : $signed({1'b0, mag});
			if (side_s[QUO_BITS-1].fl[e].pz) begin
				if (side_s[QUO_BITS-1].fl[e].rneg) rej = 1'b1;
			end else if (side_s[QUO_BITS-1].fl[e].pneg) begin
				if (ratio > tin) tin = ratio;
			end else begin
				if (ratio < tout) tout = ratio;
			end
		end
		if (tin > tout) rej = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2   <= !rej;
			tin_s2  <= tin[QUO_BITS-1:0];
			tout_s2 <= tout[QUO_BITS-1:0];
			side_s2 <= side_s[QUO_BITS-1];
			ok_s3   <= ok_s2;
			x0_s3   <= side_s2.x0;
			y0_s3   <= side_s2.y0;
			pix_s3  <= $signed({1'b0, tin_s2}) * side_s2.dx;
			piy_s3  <= $signed({1'b0, tin_s2}) * side_s2.dy;
			pox_s3  <= $signed({1'b0, tout_s2}) * side_s2.dx;
			poy_s3  <= $signed({1'b0, tout_s2}) * side_s2.dy;
			vis_q   <= ok_s3;
			sx_q    <= ok_s3 ? x0_s3 + pix_s3[FRAC_BITS +: COORD_W] : '0;
			sy_q    <= ok_s3 ? y0_s3 + piy_s3[FRAC_BITS +: COORD_W] : '0;
			ex_q    <= ok_s3 ? x0_s3 + pox_s3[FRAC_BITS +: COORD_W] : '0;
			ey_q    <= ok_s3 ? y0_s3 + poy_s3[FRAC_BITS +: COORD_W] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[QUO_BITS-2:0], q_rd};
			vld_s2    <= vld_q[QUO_BITS-1];
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	assign visible         = vis_q;
	assign clipped_start_x = sx_q;
	assign clipped_start_y = sy_q;
	assign clipped_end_x   = ex_q;
	assign clipped_end_y   = ey_q;
endmodule
